// ===== rtl/aagp_pkg.sv =====
package aagp_pkg;

    // Fixed field widths of the block's ports.
    localparam int PIXEL_W      = 8;
    localparam int INDEX_W      = 6;
    localparam int CFG_DATA_W   = 13;
    localparam int GRID_FIELD_W = 4;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GRID   = 2'd2
    } t_cfg_reg;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_DIV_START,
        S_DIV_WAIT,
        S_FILL,
        S_RUN,
        S_BAND,
        S_EMIT,
        S_MUL,
        S_AVG_START,
        S_AVG_WAIT
    } t_state;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic accum;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== rtl/area_average_grid_pooling.sv =====
// Area-average pooling of a grey image into a G x G grid of cells.
// Pixels enter on the pixel channel (i_pixel_valid / o_pixel_stall) in
// raster order; a pixel is taken at each edge with valid high and stall low.
// Cell averages leave on the cell channel (o_cell_valid / i_cell_stall)
// in raster cell order, each with its index and end-of-run/end-of-frame
// flags; an output register holds a result until the receiver takes it.
// Width, height and grid size are written through i_cfg_we / i_cfg_index /
// i_cfg_data while the block is idle; a write restarts the frame.
// After reset and after each register write the column and row band
// boundaries are computed by two serial dividers and shifted into the cell
// chain, with the pixel channel stalled.
// Inside a row one pixel is taken per cycle. At the end of each row the
// block checks for a closing band with the pixel channel stalled. A row
// that closes a band rotates the cell chain once around (MAX_GRID steps);
// each active cell goes through the count multiply and the 8-step average
// divider. The first average follows the closing pixel through S_BAND,
// S_EMIT, S_MUL, S_AVG_START and S_AVG_WAIT into the output register.
// When the receiver stalls, the emission waits and the pixel channel
// stays stalled.
module area_average_grid_pooling #(
    parameter int MAX_GRID = 8,
    parameter int MAX_DIM  = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aagp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [aagp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_stall,
    input  logic [aagp_pkg::PIXEL_W-1:0]        i_pixel,
    output logic                                o_cell_valid,
    input  logic                                i_cell_stall,
    output logic [aagp_pkg::PIXEL_W-1:0]        o_cell_average,
    output logic [aagp_pkg::INDEX_W-1:0]        o_cell_index,
    output logic                                o_last_of_run,
    output logic                                o_last_of_frame
);
    import aagp_pkg::*;

    localparam int DIM_LIMIT = (1 << CFG_DATA_W) - 1;
    localparam int DIM_CAP   = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int POS_W     = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
    localparam int DIM_W     = $clog2(DIM_CAP + 1);
    localparam int SUM_W     = PIXEL_W + 2 * POS_W;
    localparam int CNT_W     = 2 * DIM_W;
    localparam int GRID_W    = $clog2(MAX_GRID + 1);
    localparam int GIDX_W    = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int NUM_W     = DIM_W + GRID_W;
    localparam int PROD_W    = 2 * GRID_W + 1;

    // Control registers.
    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_w, n_w;
    logic [DIM_W-1:0]   r_h, n_h;
    logic [GRID_W-1:0]  r_g, n_g;
    logic [POS_W-1:0]   r_x, n_x;
    logic [POS_W-1:0]   r_y, n_y;
    logic [GRID_W-1:0]  r_band, n_band;
    logic [GRID_W-1:0]  r_ent, n_ent;
    logic [GRID_W-1:0]  r_step, n_step;
    logic               r_emitted, n_emitted;
    logic               r_out_valid, n_out_valid;

    // Payload registers.
    logic [NUM_W-1:0]   r_num_c, n_num_c;
    logic [NUM_W-1:0]   r_num_r, n_num_r;
    logic [DIM_W-1:0]   r_prev_c, n_prev_c;
    logic [DIM_W-1:0]   r_prev_r, n_prev_r;
    logic [DIM_W-1:0]   r_last_rend, n_last_rend;
    logic [DIM_W-1:0]   r_band_h, n_band_h;
    logic               r_band_last, n_band_last;
    logic [SUM_W-1:0]   r_sum_c, n_sum_c;
    logic [DIM_W-1:0]   r_wid_c, n_wid_c;
    logic [INDEX_W-1:0] r_cap_idx, n_cap_idx;
    logic               r_cap_lrun, n_cap_lrun;
    logic               r_cap_lframe, n_cap_lframe;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PIXEL_W-1:0] r_out_avg, n_out_avg;
    logic [INDEX_W-1:0] r_out_idx, n_out_idx;
    logic               r_out_lrun, n_out_lrun;
    logic               r_out_lframe, n_out_lframe;

    // Row band tables, one entry per grid row.
    logic [DIM_W-1:0]   r_row_end  [MAX_GRID];
    logic [DIM_W-1:0]   r_row_h    [MAX_GRID];
    logic               r_row_join [MAX_GRID];
    logic               w_row_we;

    // Cell chain.
    t_cell_ctl          w_ctl;
    logic [POS_W-1:0]   w_start    [MAX_GRID];
    logic [DIM_W-1:0]   w_end      [MAX_GRID];
    logic [SUM_W-1:0]   w_sum      [MAX_GRID];
    logic [POS_W-1:0]   w_tail_start;
    logic [DIM_W-1:0]   w_tail_end;
    logic [SUM_W-1:0]   w_tail_sum;

    // Dividers.
    logic               w_bdiv_start;
    logic               w_bdiv_busy_c;
    logic               w_bdiv_busy_r;
    logic [DIM_W-1:0]   w_quo_c;
    logic [DIM_W-1:0]   w_quo_r;
    logic               w_avg_start;
    logic               w_avg_busy;
    logic [PIXEL_W-1:0] w_avg_quo;

    // Helpers.
    logic [DIM_W-1:0]   w_end_c;
    logic [DIM_W-1:0]   w_end_r;
    logic [DIM_W-1:0]   w_cfg_dim;
    logic [GRID_W-1:0]  w_cfg_grid;
    logic [GRID_W-1:0]  w_band_nx;
    logic [GIDX_W-1:0]  w_bidx;
    logic [GIDX_W-1:0]  w_nidx;
    logic [GIDX_W-1:0]  w_eidx;
    logic               w_band_hit;
    logic               w_last_row;
    logic [PROD_W-1:0]  w_idx_full;
    logic [PROD_W-1:0]  w_idx_last;
    logic [DIM_W-1:0]   w_cell0_wid;

    // Band boundary dividers: floor(g*W/G) and floor(g*H/G).
    aagp_div #(
        .NUM_W (NUM_W),
        .DEN_W (GRID_W),
        .QUO_W (DIM_W)
    ) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bdiv_start),
        .i_num   (r_num_c),
        .i_den   (r_g),
        .o_busy  (w_bdiv_busy_c),
        .o_quo   (w_quo_c)
    );

    aagp_div #(
        .NUM_W (NUM_W),
        .DEN_W (GRID_W),
        .QUO_W (DIM_W)
    ) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bdiv_start),
        .i_num   (r_num_r),
        .i_den   (r_g),
        .o_busy  (w_bdiv_busy_r),
        .o_quo   (w_quo_r)
    );

    // Cell average divider: sum / (cell width * band height).
    aagp_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W),
        .QUO_W (PIXEL_W)
    ) u_div_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_avg_start),
        .i_num   (r_sum_c),
        .i_den   (r_cnt),
        .o_busy  (w_avg_busy),
        .o_quo   (w_avg_quo)
    );

    // Chain of grid column cells; the tail takes new entries during setup
    // and the head's state during emission, which makes the chain a ring.
    for (genvar g = 0; g < MAX_GRID; g++) begin : g_cell
        logic [POS_W-1:0] w_nb_start;
        logic [DIM_W-1:0] w_nb_end;
        logic [SUM_W-1:0] w_nb_sum;

        if (g == MAX_GRID - 1) begin : g_tail
            assign w_nb_start = w_tail_start;
            assign w_nb_end   = w_tail_end;
            assign w_nb_sum   = w_tail_sum;
        end else begin : g_link
            assign w_nb_start = w_start[g+1];
            assign w_nb_end   = w_end[g+1];
            assign w_nb_sum   = w_sum[g+1];
        end

        aagp_cell #(
            .POS_W (POS_W),
            .DIM_W (DIM_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_x        (r_x),
            .i_pixel    (i_pixel),
            .i_nb_start (w_nb_start),
            .i_nb_end   (w_nb_end),
            .i_nb_sum   (w_nb_sum),
            .o_start    (w_start[g]),
            .o_end      (w_end[g]),
            .o_sum      (w_sum[g])
        );
    end

    // A span is at least one wide, so an empty span ends one past its start.
    assign w_end_c = (w_quo_c == r_prev_c) ? r_prev_c + 1'b1 : w_quo_c;
    assign w_end_r = (w_quo_r == r_prev_r) ? r_prev_r + 1'b1 : w_quo_r;

    // Tail input of the chain.
    always_comb begin
        if (r_state == S_EMIT) begin
            w_tail_start = w_start[0];
            w_tail_end   = w_end[0];
            w_tail_sum   = w_sum[0];
        end else if (r_state == S_DIV_WAIT) begin
            w_tail_start = r_prev_c[POS_W-1:0];
            w_tail_end   = w_end_c;
            w_tail_sum   = '0;
        end else begin
            w_tail_start = '0;
            w_tail_end   = '0;
            w_tail_sum   = '0;
        end
    end

    // Clamped register values: zero means one, larger values saturate.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_dim = DIM_W'(1);
        end else if (int'(i_cfg_data) > MAX_DIM) begin
            w_cfg_dim = DIM_W'(DIM_CAP);
        end else begin
            w_cfg_dim = DIM_W'(i_cfg_data);
        end
        if (i_cfg_data[GRID_FIELD_W-1:0] == '0) begin
            w_cfg_grid = GRID_W'(1);
        end else if (int'(i_cfg_data[GRID_FIELD_W-1:0]) > MAX_GRID) begin
            w_cfg_grid = GRID_W'(MAX_GRID);
        end else begin
            w_cfg_grid = GRID_W'(i_cfg_data[GRID_FIELD_W-1:0]);
        end
    end

    // Band lookups and cell index arithmetic.
    assign w_band_nx   = GRID_W'(r_band + 1'b1);
    assign w_bidx      = r_band[GIDX_W-1:0];
    assign w_nidx      = w_band_nx[GIDX_W-1:0];
    assign w_eidx      = r_ent[GIDX_W-1:0];
    assign w_band_hit  = (r_band < r_g) && (r_row_end[w_bidx] == DIM_W'(r_y) + 1'b1);
    assign w_last_row  = (DIM_W'(r_y) + 1'b1 == r_h);
    assign w_idx_full  = PROD_W'(r_band) * PROD_W'(r_g) + PROD_W'(r_step);
    assign w_idx_last  = PROD_W'(r_g) * PROD_W'(r_g) - 1'b1;
    assign w_cell0_wid = w_end[0] - DIM_W'(w_start[0]);

    // Next state and outputs of the controller.
    always_comb begin
        n_state      = r_state;
        n_w          = r_w;
        n_h          = r_h;
        n_g          = r_g;
        n_x          = r_x;
        n_y          = r_y;
        n_band       = r_band;
        n_ent        = r_ent;
        n_step       = r_step;
        n_emitted    = r_emitted;
        n_out_valid  = r_out_valid & i_cell_stall;
        n_num_c      = r_num_c;
        n_num_r      = r_num_r;
        n_prev_c     = r_prev_c;
        n_prev_r     = r_prev_r;
        n_last_rend  = r_last_rend;
        n_band_h     = r_band_h;
        n_band_last  = r_band_last;
        n_sum_c      = r_sum_c;
        n_wid_c      = r_wid_c;
        n_cap_idx    = r_cap_idx;
        n_cap_lrun   = r_cap_lrun;
        n_cap_lframe = r_cap_lframe;
        n_cnt        = r_cnt;
        n_out_avg    = r_out_avg;
        n_out_idx    = r_out_idx;
        n_out_lrun   = r_out_lrun;
        n_out_lframe = r_out_lframe;
        w_ctl        = '0;
        w_row_we     = 1'b0;
        w_bdiv_start = 1'b0;
        w_avg_start  = 1'b0;

        unique case (r_state)
            S_INIT: begin
                n_ent       = '0;
                n_num_c     = NUM_W'(r_w);
                n_num_r     = NUM_W'(r_h);
                n_prev_c    = '0;
                n_prev_r    = '0;
                n_last_rend = '0;
                n_x         = '0;
                n_y         = '0;
                n_band      = '0;
                n_emitted   = 1'b0;
                n_state     = S_DIV_START;
            end
            S_DIV_START: begin
                w_bdiv_start = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                // Shift the finished column span in and record the band.
                if (!w_bdiv_busy_c && !w_bdiv_busy_r) begin
                    w_ctl.shift = 1'b1;
                    w_row_we    = 1'b1;
                    n_prev_c    = w_quo_c;
                    n_prev_r    = w_quo_r;
                    n_last_rend = w_end_r;
                    n_num_c     = r_num_c + NUM_W'(r_w);
                    n_num_r     = r_num_r + NUM_W'(r_h);
                    n_ent       = GRID_W'(r_ent + 1'b1);
                    if (GRID_W'(r_ent + 1'b1) == r_g) begin
                        n_state = (r_g == GRID_W'(MAX_GRID)) ? S_RUN : S_FILL;
                    end else begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_FILL: begin
                // Unused grid columns get an empty span.
                w_ctl.shift = 1'b1;
                n_ent       = GRID_W'(r_ent + 1'b1);
                if (GRID_W'(r_ent + 1'b1) == GRID_W'(MAX_GRID)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_pixel_valid) begin
                    w_ctl.accum = 1'b1;
                    if (DIM_W'(r_x) + 1'b1 < r_w) begin
                        n_x = POS_W'(r_x + 1'b1);
                    end else begin
                        n_x       = '0;
                        n_emitted = 1'b0;
                        n_state   = S_BAND;
                    end
                end
            end
            S_BAND: begin
                if (w_band_hit) begin
                    n_band_h    = r_row_h[w_bidx];
                    n_band_last = !((w_band_nx < r_g) && r_row_join[w_nidx]);
                    n_step      = '0;
                    n_state     = S_EMIT;
                end else begin
                    // Row is closed: clear sums after emission or at frame end.
                    w_ctl.clear = r_emitted || w_last_row;
                    if (w_last_row) begin
                        n_y    = '0;
                        n_band = '0;
                    end else begin
                        n_y = POS_W'(r_y + 1'b1);
                    end
                    n_state = S_RUN;
                end
            end
            S_EMIT: begin
                if (r_step == GRID_W'(MAX_GRID)) begin
                    n_band    = w_band_nx;
                    n_emitted = 1'b1;
                    n_state   = S_BAND;
                end else begin
                    // Rotate the ring one step; the head is the next cell.
                    w_ctl.shift = 1'b1;
                    n_step      = GRID_W'(r_step + 1'b1);
                    if (r_step < r_g) begin
                        n_sum_c      = w_sum[0];
                        n_wid_c      = w_cell0_wid;
                        n_cap_idx    = INDEX_W'(w_idx_full);
                        n_cap_lframe = (w_idx_full == w_idx_last);
                        n_cap_lrun   = r_band_last &&
                                       (GRID_W'(r_step + 1'b1) == r_g);
                        n_state      = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_cnt   = CNT_W'(r_wid_c) * CNT_W'(r_band_h);
                n_state = S_AVG_START;
            end
            S_AVG_START: begin
                w_avg_start = 1'b1;
                n_state     = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (!w_avg_busy && (!r_out_valid || !i_cell_stall)) begin
                    n_out_valid  = 1'b1;
                    n_out_avg    = w_avg_quo;
                    n_out_idx    = r_cap_idx;
                    n_out_lrun   = r_cap_lrun;
                    n_out_lframe = r_cap_lframe;
                    n_state      = S_EMIT;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // A write to a defined register restarts the frame and recomputes the spans.
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WIDTH: begin
                    n_w     = w_cfg_dim;
                    n_state = S_INIT;
                end
                CFG_HEIGHT: begin
                    n_h     = w_cfg_dim;
                    n_state = S_INIT;
                end
                CFG_GRID: begin
                    n_g     = w_cfg_grid;
                    n_state = S_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_w         <= DIM_W'(1);
            r_h         <= DIM_W'(1);
            r_g         <= GRID_W'(1);
            r_x         <= '0;
            r_y         <= '0;
            r_band      <= '0;
            r_ent       <= '0;
            r_step      <= '0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_h         <= n_h;
            r_g         <= n_g;
            r_x         <= n_x;
            r_y         <= n_y;
            r_band      <= n_band;
            r_ent       <= n_ent;
            r_step      <= n_step;
            r_emitted   <= n_emitted;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_num_c      <= n_num_c;
        r_num_r      <= n_num_r;
        r_prev_c     <= n_prev_c;
        r_prev_r     <= n_prev_r;
        r_last_rend  <= n_last_rend;
        r_band_h     <= n_band_h;
        r_band_last  <= n_band_last;
        r_sum_c      <= n_sum_c;
        r_wid_c      <= n_wid_c;
        r_cap_idx    <= n_cap_idx;
        r_cap_lrun   <= n_cap_lrun;
        r_cap_lframe <= n_cap_lframe;
        r_cnt        <= n_cnt;
        r_out_avg    <= n_out_avg;
        r_out_idx    <= n_out_idx;
        r_out_lrun   <= n_out_lrun;
        r_out_lframe <= n_out_lframe;
    end

    // Row band table, written once per band during setup.
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_row_end[w_eidx]  <= w_end_r;
            r_row_h[w_eidx]    <= w_end_r - r_prev_r;
            r_row_join[w_eidx] <= (r_ent != '0) && (w_end_r == r_last_rend);
        end
    end

    assign o_pixel_stall   = (r_state != S_RUN);
    assign o_cell_valid    = r_out_valid;
    assign o_cell_average  = r_out_avg;
    assign o_cell_index    = r_out_idx;
    assign o_last_of_run   = r_out_lrun;
    assign o_last_of_frame = r_out_lframe;

    // The ring is back in place whenever pixels are taken.
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (w_start[0] == '0))
        else $error("cell ring not aligned while taking pixels");

    // The final cell of an image always closes the run.
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && o_last_of_frame) |-> o_last_of_run)
        else $error("last cell of frame without end of run");

    // Emission only walks bands of the grid.
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_band < r_g))
        else $error("band index beyond grid during emission");

    // Raster position stays inside the image.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((DIM_W'(r_x) < r_w) && (DIM_W'(r_y) < r_h)))
        else $error("raster position outside image");

    // The average divider is idle when a new cell is started.
    a_avg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG_START) |-> !w_avg_busy)
        else $error("average divider restarted while busy");

endmodule

// ===== rtl/aagp_cell.sv =====
module aagp_cell #(
    parameter int POS_W = 12,
    parameter int DIM_W = 13,
    parameter int SUM_W = 32
) (
    input  logic                           i_clk,
    input  aagp_pkg::t_cell_ctl            i_ctl,
    input  logic [POS_W-1:0]               i_x,
    input  logic [aagp_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [POS_W-1:0]               i_nb_start,
    input  logic [DIM_W-1:0]               i_nb_end,
    input  logic [SUM_W-1:0]               i_nb_sum,
    output logic [POS_W-1:0]               o_start,
    output logic [DIM_W-1:0]               o_end,
    output logic [SUM_W-1:0]               o_sum
);
    import aagp_pkg::*;

    logic [POS_W-1:0] r_start;
    logic [DIM_W-1:0] r_end;
    logic [SUM_W-1:0] r_sum;
    logic             w_hit;

    // The pixel belongs to this grid column when x lies in [start, end).
    assign w_hit = (i_x >= r_start) && (DIM_W'(i_x) < r_end);

    // Shifting takes the whole state of the right neighbor; otherwise the
    // running sum is cleared or accumulates the broadcast pixel.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_start <= i_nb_start;
            r_end   <= i_nb_end;
            r_sum   <= i_nb_sum;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.accum && w_hit) begin
            r_sum <= r_sum + SUM_W'(i_pixel);
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/aagp_div.sv =====
module aagp_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 26,
    parameter int QUO_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quo
);
    import aagp_pkg::*;

    localparam int SH_W   = DEN_W + QUO_W;
    localparam int CMP_W  = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int CNTR_W = $clog2(QUO_W + 1);

    logic [CMP_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [CNTR_W-1:0] r_cnt;
    logic              r_busy;
    logic              w_ge;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The quotient is known to fit in QUO_W bits.
    assign w_ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTR_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNTR_W'(1));
        end
    end

    // Datapath of the divider.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CMP_W'(i_num);
            r_den <= CMP_W'(i_den) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_den;
            end
            r_den <= r_den >> 1;
            r_quo <= QUO_W'({r_quo, w_ge});
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== sim/tb_area_average_grid_pooling.sv =====
`timescale 1ns / 100ps

module tb_area_average_grid_pooling;

    import aagp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_PIXELS = 360;
    localparam int SAT_PIXELS    = 16;
    localparam int GRID_LIMIT    = 8;
    localparam int DIM_LIMIT     = 4096;
    localparam int REPORT_LINES  = 200;

    // Index past the register list; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    // One expected cell transfer.
    typedef struct {
        bit [PIXEL_W-1:0] average;
        bit [INDEX_W-1:0] index;
        bit               run_end;
        bit               frame_end;
    } t_cell;

    // Predicts the cell averages from the accepted pixels and checks the results.
    class grid_pool_scoreboard;
        bit [CFG_DATA_W-1:0]   reg_width;
        bit [CFG_DATA_W-1:0]   reg_height;
        bit [GRID_FIELD_W-1:0] reg_grid;
        int unsigned           col;
        int unsigned           row;
        int unsigned           band;
        longint unsigned       col_sum [GRID_LIMIT];
        int unsigned           col_lo [GRID_LIMIT];
        int unsigned           col_hi [GRID_LIMIT];
        t_cell                 cells_due [$];
        int                    errors;

        function int unsigned eff_dim(bit [CFG_DATA_W-1:0] v);
            if (v == 0) return 1;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return v;
        endfunction

        function int unsigned eff_grid();
            if (reg_grid == 0) return 1;
            if (reg_grid > GRID_LIMIT) return GRID_LIMIT;
            return reg_grid;
        endfunction

        function int unsigned frame_pixels();
            return eff_dim(reg_width) * eff_dim(reg_height);
        endfunction

        // First and one-past-last coordinate of grid line g; never empty.
        function void cell_span(int unsigned g, int unsigned dim, int unsigned n,
                                output int unsigned first, output int unsigned stop);
            first = g * dim / n;
            stop  = (g + 1) * dim / n;
            if (stop < first + 1) stop = first + 1;
        endfunction

        // Start a new frame and rebuild the column boundaries.
        function void restart();
            int unsigned n;
            n    = eff_grid();
            col  = 0;
            row  = 0;
            band = 0;
            for (int g = 0; g < GRID_LIMIT; g++) begin
                col_sum[g] = 0;
                if (g < n) begin
                    cell_span(g, eff_dim(reg_width), n, col_lo[g], col_hi[g]);
                end else begin
                    col_lo[g] = 0;
                    col_hi[g] = 0;
                end
            end
        endfunction

        function void power_on();
            reg_width  = 1;
            reg_height = 1;
            reg_grid   = 1;
            errors     = 0;
            restart();
        endfunction

        function void write_reg(bit [CFG_INDEX_W-1:0] sel, bit [CFG_DATA_W-1:0] data);
            case (sel)
                CFG_WIDTH: begin
                    reg_width = data;
                end
                CFG_HEIGHT: begin
                    reg_height = data;
                end
                CFG_GRID: begin
                    reg_grid = data[GRID_FIELD_W-1:0];
                end
                default: begin
                    return;
                end
            endcase
            restart();
        endfunction

        // Accumulate one accepted pixel and queue every cell it closes.
        function void take_pixel(bit [PIXEL_W-1:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned n;
            int unsigned y0;
            int unsigned y1;
            int unsigned area;
            longint unsigned mean;
            bit closed;
            t_cell c;
            w      = eff_dim(reg_width);
            h      = eff_dim(reg_height);
            n      = eff_grid();
            closed = 0;
            for (int g = 0; g < n; g++) begin
                if (col >= col_lo[g] && col < col_hi[g]) col_sum[g] += px;
            end
            if (col + 1 < w) begin
                col++;
                return;
            end
            // End of row: every band whose last row is this one is emitted.
            while (band < n) begin
                cell_span(band, h, n, y0, y1);
                if (y1 - 1 != row) break;
                for (int g = 0; g < n; g++) begin
                    area        = (col_hi[g] - col_lo[g]) * (y1 - y0);
                    mean        = col_sum[g] / area;
                    c.average   = mean[PIXEL_W-1:0];
                    c.index     = INDEX_W'(band * n + g);
                    c.run_end   = 0;
                    c.frame_end = (band * n + g == n * n - 1);
                    cells_due   = {cells_due, c};
                end
                band++;
                closed = 1;
            end
            if (closed) begin
                foreach (col_sum[g]) col_sum[g] = 0;
                cells_due[cells_due.size() - 1].run_end = 1;
            end
            col = 0;
            if (row + 1 < h) begin
                row++;
            end else begin
                row  = 0;
                band = 0;
                foreach (col_sum[g]) col_sum[g] = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES) $display("%0t ns: cell mismatch: %s", $time, msg);
        endtask

        task check_cell(bit [PIXEL_W-1:0] avg, bit [INDEX_W-1:0] idx,
                        bit run_end, bit frame_end);
            t_cell want;
            if (cells_due.size() == 0) begin
                report($sformatf("cell %0d (average %0d) with nothing expected", idx, avg));
                return;
            end
            want = cells_due.pop_front();
            if (avg != want.average)
                report($sformatf("cell %0d average %0d, expected %0d", idx, avg, want.average));
            if (idx != want.index)
                report($sformatf("cell index %0d, expected %0d", idx, want.index));
            if (run_end != want.run_end)
                report($sformatf("cell %0d last_of_run %0b, expected %0b",
                                 idx, run_end, want.run_end));
            if (frame_end != want.frame_end)
                report($sformatf("cell %0d last_of_frame %0b, expected %0b",
                                 idx, frame_end, want.frame_end));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_pixel_valid;
    logic                    o_pixel_stall;
    logic [PIXEL_W-1:0]      i_pixel;
    logic                    o_cell_valid;
    logic                    i_cell_stall = 1'b0;
    logic [PIXEL_W-1:0]      o_cell_average;
    logic [INDEX_W-1:0]      o_cell_index;
    logic                    o_last_of_run;
    logic                    o_last_of_frame;

    grid_pool_scoreboard sb = new();
    int snd_idle_pct  = 10;
    int rcv_stall_pct = 46;
    int random_sent;

    area_average_grid_pooling dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_valid   (i_pixel_valid),
        .o_pixel_stall   (o_pixel_stall),
        .i_pixel         (i_pixel),
        .o_cell_valid    (o_cell_valid),
        .i_cell_stall    (i_cell_stall),
        .o_cell_average  (o_cell_average),
        .o_cell_index    (o_cell_index),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_frame (o_last_of_frame)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cell receiver: check each transfer, then choose the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_cell_valid && !i_cell_stall)
            sb.check_cell(o_cell_average, o_cell_index, o_last_of_run, o_last_of_frame);
        i_cell_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Present one pixel after a random gap and hold it until the transfer.
    task automatic send_pixel(input bit [PIXEL_W-1:0] px);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_pixel_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel       <= px;
        do @(posedge i_clk); while (o_pixel_stall);
        sb.take_pixel(px);
    endtask

    // Stop sending and wait until every expected cell has arrived.
    task automatic drain_cells();
        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (sb.cells_due.size() != 0);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic cfg_write(input bit [CFG_INDEX_W-1:0] sel,
                             input bit [CFG_DATA_W-1:0] data);
        drain_cells();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(sel, data);
    endtask

    task automatic send_frame(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(PIXEL_W'($urandom_range(0, 255)));
    endtask

    function automatic bit [CFG_DATA_W-1:0] pick_dim();
        if ($urandom_range(99) < 8) return 0;
        return CFG_DATA_W'($urandom_range(1, 9));
    endfunction

    function automatic bit [PIXEL_W-1:0] pick_pixel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return 0;
        if (roll < 30) return 8'hFF;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned count;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_WIDTH;
        i_cfg_data    <= '0;
        i_pixel_valid <= 1'b0;
        i_pixel       <= '0;
        sb.power_on();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting is a single pixel per frame.
        send_pixel(8'hFF);
        send_pixel(8'h00);

        // Zero registers behave as one.
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 0);
        cfg_write(CFG_GRID, 0);
        send_pixel(8'h80);

        // Grid larger than the image: cells overlap single rows and columns.
        cfg_write(CFG_WIDTH, 3);
        cfg_write(CFG_HEIGHT, 2);
        cfg_write(CFG_GRID, 5);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h01);
        send_pixel(8'h02);
        send_pixel(8'hFE);
        send_pixel(8'h80);

        // A register write abandons the frame in progress.
        cfg_write(CFG_WIDTH, 2);
        cfg_write(CFG_GRID, 2);
        send_pixel(8'h55);
        cfg_write(CFG_GRID, 2);
        send_frame(4);

        // A write past the register list leaves the frame running.
        send_pixel(8'hAA);
        send_pixel(8'h0F);
        cfg_write(CFG_SPARE, 13'h1ABC);
        send_pixel(8'hF0);
        send_pixel(8'h33);

        // Saturated width: a short stretch of a long row closes nothing.
        cfg_write(CFG_WIDTH, 13'h1FFF);
        cfg_write(CFG_HEIGHT, 1);
        cfg_write(CFG_GRID, 15);
        for (int i = 0; i < SAT_PIXELS; i++) send_pixel(pick_pixel());

        // Saturated height, one pixel per row, still inside the first band.
        cfg_write(CFG_WIDTH, 1);
        cfg_write(CFG_HEIGHT, 13'd4097);
        cfg_write(CFG_GRID, 8);
        for (int i = 0; i < SAT_PIXELS; i++) send_pixel(8'hFF);

        // Random frames under three idling patterns.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent < RANDOM_PIXELS / 3) begin
                snd_idle_pct  = 10;
                rcv_stall_pct = 46;
            end else if (random_sent < 2 * RANDOM_PIXELS / 3) begin
                snd_idle_pct  = 46;
                rcv_stall_pct = 10;
            end else begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 0;
            end
            if ($urandom_range(99) < 60) cfg_write(CFG_WIDTH, pick_dim());
            if ($urandom_range(99) < 60) cfg_write(CFG_HEIGHT, pick_dim());
            if ($urandom_range(99) < 60) begin
                if ($urandom_range(1)) cfg_write(CFG_GRID, CFG_DATA_W'($urandom_range(0, 15)));
                else cfg_write(CFG_GRID, CFG_DATA_W'($urandom_range(0, 8191)));
            end
            if ($urandom_range(99) < 5)
                cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
            repeat ($urandom_range(1, 2)) begin
                count = sb.frame_pixels();
                if ($urandom_range(99) < 12) count = $urandom_range(1, count);
                for (int unsigned i = 0; i < count; i++) begin
                    // Now and then the source waits for the output to run dry.
                    if ($urandom_range(99) < 3) drain_cells();
                    send_pixel(pick_pixel());
                    random_sent++;
                end
            end
        end

        drain_cells();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[area_average_grid_pooling] OK");
        end else begin
            $display("[area_average_grid_pooling] ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(40_000_000);
        $display("[area_average_grid_pooling] ERROR");
        $finish;
    end

endmodule
